/* hw/rtl/clrc_pkg.sv */
package clrc_pkg;

  localparam int REC_BYTES_DEF = 40;
  localparam int MAX_PAY_DEF   = 8;
  localparam int POS_W         = 6;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int          CRC_AT   = 36;
  localparam logic [7:0]  TYPE_RX  = 8'd1;

  localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h56, 8'h43, 8'h4C};

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic CFG_VERSION = 1'b0;
  localparam logic CFG_PORT    = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } enc_status_t;

  typedef struct packed {
    logic        last;
    logic        ok;
    logic [63:0] sequence_no;
    logic [31:0] timestamp;
    logic [31:0] ident;
    logic [7:0]  length;
    logic        extended;
    logic [63:0] payload;
  } dec_result_t;

  // One reflected CRC-32 byte update, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/clrc_encoder.sv */
module clrc_encoder import clrc_pkg::*; #(
  parameter int RECORD_BYTES      = REC_BYTES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  port,
  input  logic        extended_flag,
  input  logic [63:0] seq_number,
  input  logic [31:0] frame_time,
  input  logic [31:0] frame_id,
  input  logic [3:0]  data_length,
  input  logic [63:0] payload,
  input  logic [7:0]  version,
  output enc_status_t status
);

  logic [POS_W-1:0] pos;
  logic [31:0]      crc;
  logic [7:0]       cur_byte;
  logic [POS_W-1:0] off;
  logic [31:0]      crc_out;

  assign crc_out = ~crc;

  always_comb begin
    cur_byte = 8'd0;
    off      = '0;
    priority if (pos < POS_W'(4)) begin
      cur_byte = MAGIC[pos[1:0]];
    end else if (pos == POS_W'(4)) begin
      cur_byte = version;
    end else if (pos == POS_W'(5)) begin
      cur_byte = TYPE_RX;
    end else if (pos == POS_W'(6)) begin
      cur_byte = port;
    end else if (pos == POS_W'(7)) begin
      cur_byte = {7'd0, extended_flag};
    end else if (pos < POS_W'(16)) begin
      off      = pos - POS_W'(8);
      cur_byte = seq_number[8*off[2:0] +: 8];
    end else if (pos < POS_W'(20)) begin
      off      = pos - POS_W'(16);
      cur_byte = frame_time[8*off[1:0] +: 8];
    end else if (pos < POS_W'(24)) begin
      off      = pos - POS_W'(20);
      cur_byte = frame_id[8*off[1:0] +: 8];
    end else if (pos == POS_W'(24)) begin
      cur_byte = {4'd0, data_length};
    end else if (pos < POS_W'(25 + MAX_PAYLOAD_BYTES)) begin
      off = pos - POS_W'(25);
      if (off < POS_W'(data_length)) begin
        cur_byte = payload[8*off[2:0] +: 8];
      end
    end else if (pos >= POS_W'(CRC_AT) && pos < POS_W'(CRC_AT + 4)) begin
      off      = pos - POS_W'(CRC_AT);
      cur_byte = crc_out[8*off[1:0] +: 8];
    end else begin
      cur_byte = 8'd0;
    end
  end

  assign status.out_byte = cur_byte;
  assign status.last     = (pos == POS_W'(RECORD_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= CRC_INIT;
    end else if (step) begin
      if (status.last) begin
        pos <= '0;
        crc <= CRC_INIT;
      end else begin
        pos <= pos + POS_W'(1);
        if (pos < POS_W'(CRC_AT)) begin
          crc <= crc_byte(crc, cur_byte);
        end
      end
    end
  end

endmodule

/* hw/rtl/clrc_decoder.sv */
module clrc_decoder import clrc_pkg::*; #(
  parameter int RECORD_BYTES      = REC_BYTES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  record_byte,
  input  logic [7:0]  version,
  input  logic [7:0]  accepted_port,
  output dec_result_t result
);

  logic [POS_W-1:0] pos;
  logic [31:0]      crc, crc_next;
  logic             hg, hg_next;
  logic [63:0]      seq, seq_next;
  logic [31:0]      ts, ts_next;
  logic [31:0]      id, id_next;
  logic [7:0]       len, len_next;
  logic             ext, ext_next;
  logic [63:0]      pay, pay_next;
  logic [31:0]      scrc, scrc_next;
  logic             last;

  assign last = (pos == POS_W'(RECORD_BYTES - 1));

  always_comb begin
    crc_next  = (pos < POS_W'(CRC_AT)) ? crc_byte(crc, record_byte) : crc;
    hg_next   = hg;
    ext_next  = ext;
    len_next  = len;
    seq_next  = seq;
    ts_next   = ts;
    id_next   = id;
    pay_next  = pay;
    scrc_next = scrc;
    priority if (pos < POS_W'(4)) begin
      if (record_byte != MAGIC[pos[1:0]]) hg_next = 1'b0;
    end else if (pos == POS_W'(4)) begin
      if (record_byte != version) hg_next = 1'b0;
    end else if (pos == POS_W'(5)) begin
      if (record_byte != TYPE_RX) hg_next = 1'b0;
    end else if (pos == POS_W'(6)) begin
      if (record_byte != accepted_port) hg_next = 1'b0;
    end else if (pos == POS_W'(7)) begin
      ext_next = record_byte[0];
    end else if (pos == POS_W'(24)) begin
      len_next = record_byte;
    end else begin
      hg_next = hg;
    end
    for (int i = 0; i < 8; i++) begin
      if (pos == POS_W'(8 + i)) seq_next[8*i +: 8] = seq[8*i +: 8] | record_byte;
      if (i < MAX_PAYLOAD_BYTES && pos == POS_W'(25 + i)) begin
        pay_next[8*i +: 8] = pay[8*i +: 8] | record_byte;
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (pos == POS_W'(16 + i)) ts_next[8*i +: 8] = ts[8*i +: 8] | record_byte;
      if (pos == POS_W'(20 + i)) id_next[8*i +: 8] = id[8*i +: 8] | record_byte;
      if (pos == POS_W'(CRC_AT + i)) scrc_next[8*i +: 8] = scrc[8*i +: 8] | record_byte;
    end
  end

  always_comb begin
    result.last        = last;
    result.ok          = hg_next && (len_next <= 8'(MAX_PAYLOAD_BYTES)) &&
                         (scrc_next == ~crc_next);
    result.sequence_no = seq_next;
    result.timestamp   = ts_next;
    result.ident       = id_next;
    result.length      = len_next;
    result.extended    = ext_next;
    for (int i = 0; i < 8; i++) begin
      result.payload[8*i +: 8] = (8'(i) < len_next) ? pay_next[8*i +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      pos  <= '0;
      crc  <= CRC_INIT;
      hg   <= 1'b1;
      seq  <= '0;
      ts   <= '0;
      id   <= '0;
      len  <= '0;
      ext  <= 1'b0;
      pay  <= '0;
      scrc <= '0;
    end else if (step) begin
      pos  <= pos + POS_W'(1);
      crc  <= crc_next;
      hg   <= hg_next;
      seq  <= seq_next;
      ts   <= ts_next;
      id   <= id_next;
      len  <= len_next;
      ext  <= ext_next;
      pay  <= pay_next;
      scrc <= scrc_next;
    end
  end

endmodule

/* hw/rtl/can_log_record_codec.sv */
// Timing: a transaction accepted into the input slot is worked from there; its first
//   result (record byte 0, or the decode result) goes to the result register when free.
// Throughput: while the result register is free, decode takes one record byte per
//   cycle and encode emits one; a frame holds the byte generator until its last byte.
// Reset (rst, synchronous, active high): clears the item and result slots, the encoder
//   and decoder state, format_version to 1 and accepted_port to 0.
module can_log_record_codec import clrc_pkg::*; #(
  parameter int RECORD_BYTES      = REC_BYTES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  port,
  input  logic        extended_flag,
  input  logic [63:0] seq_number,
  input  logic [31:0] frame_time,
  input  logic [31:0] frame_id,
  input  logic [3:0]  data_length,
  input  logic [63:0] payload,
  input  logic [7:0]  record_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_flag,
  output logic        record_ok,
  output logic [63:0] decoded_sequence,
  output logic [31:0] decoded_timestamp,
  output logic [31:0] decoded_id,
  output logic [7:0]  decoded_length,
  output logic        decoded_extended,
  output logic [63:0] decoded_payload
);

  logic [7:0] format_version;
  logic [7:0] accepted_port;

  // Input slot: one held transaction
  logic        cur_valid;
  logic        cur_mode;
  logic [7:0]  cur_port;
  logic        cur_ext;
  logic [63:0] cur_seq;
  logic [31:0] cur_ts;
  logic [31:0] cur_id;
  logic [3:0]  cur_dlc;
  logic [63:0] cur_pay;
  logic [7:0]  cur_rbyte;

  enc_status_t enc;
  dec_result_t dec;

  logic slot_free;   // result register can take a new result this cycle
  logic advance;     // held item does one step of work
  logic produce;     // that work yields a result
  logic consumed;    // held item is finished and leaves the slot

  assign slot_free = !out_valid || out_ready;
  assign advance   = cur_valid && slot_free;
  assign produce   = (cur_mode == MODE_ENCODE) || dec.last;
  assign consumed  = advance && ((cur_mode == MODE_DECODE) || enc.last);
  assign in_ready  = !cur_valid || consumed;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      format_version <= 8'd1;
      accepted_port  <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERSION: format_version <= cfg_data;
        CFG_PORT:    accepted_port  <= cfg_data;
        default:     format_version <= format_version;
      endcase
    end
  end

  // Load a new transaction into the slot, drop it once finished
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      cur_valid <= 1'b1;
    end else if (consumed) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_mode  <= mode;
      cur_port  <= port;
      cur_ext   <= extended_flag;
      cur_seq   <= seq_number;
      cur_ts    <= frame_time;
      cur_id    <= frame_id;
      cur_dlc   <= data_length;
      cur_pay   <= payload;
      cur_rbyte <= record_byte;
    end
  end

  // Encoder: walks the record one byte per step, running the CRC as it goes
  clrc_encoder #(
    .RECORD_BYTES      (RECORD_BYTES),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_enc (
    .clk           (clk),
    .rst           (rst),
    .step          (advance && (cur_mode == MODE_ENCODE)),
    .port          (cur_port),
    .extended_flag (cur_ext),
    .seq_number    (cur_seq),
    .frame_time    (cur_ts),
    .frame_id      (cur_id),
    .data_length   (cur_dlc),
    .payload       (cur_pay),
    .version       (format_version),
    .status        (enc)
  );

  // Decoder: gathers one record byte per step, reports at the final byte
  clrc_decoder #(
    .RECORD_BYTES      (RECORD_BYTES),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_dec (
    .clk           (clk),
    .rst           (rst),
    .step          (advance && (cur_mode == MODE_DECODE)),
    .record_byte   (cur_rbyte),
    .version       (format_version),
    .accepted_port (accepted_port),
    .result        (dec)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      if (cur_mode == MODE_ENCODE) begin
        out_byte          <= enc.out_byte;
        last_flag         <= enc.last;
        record_ok         <= 1'b0;
        decoded_sequence  <= '0;
        decoded_timestamp <= '0;
        decoded_id        <= '0;
        decoded_length    <= '0;
        decoded_extended  <= 1'b0;
        decoded_payload   <= '0;
      end else begin
        out_byte          <= 8'd0;
        last_flag         <= 1'b1;
        record_ok         <= dec.ok;
        decoded_sequence  <= dec.sequence_no;
        decoded_timestamp <= dec.timestamp;
        decoded_id        <= dec.ident;
        decoded_length    <= dec.length;
        decoded_extended  <= dec.extended;
        decoded_payload   <= dec.payload;
      end
    end
  end

`ifndef SYNTH
  // An empty slot must always be open for the next transaction
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> in_ready)
    else $error("input slot empty but not ready");

  // A passing decode result is always a final result with a zero byte
  a_ok_is_decode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_ok) |-> (last_flag && (out_byte == 8'd0)))
    else $error("record_ok on a non-decode result");

  // A held item stalled by the output keeps its slot
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !slot_free) |=> cur_valid)
    else $error("held item lost while output stalled");
`endif

endmodule

/* bench/clrc_record_checker.sv */
module clrc_record_checker import clrc_pkg::*; #(
  parameter int RECORD_BYTES      = REC_BYTES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  port,
  input  logic        extended_flag,
  input  logic [63:0] seq_number,
  input  logic [31:0] frame_time,
  input  logic [31:0] frame_id,
  input  logic [3:0]  data_length,
  input  logic [63:0] payload,
  input  logic [7:0]  record_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        last_flag,
  input  logic        record_ok,
  input  logic [63:0] decoded_sequence,
  input  logic [31:0] decoded_timestamp,
  input  logic [31:0] decoded_id,
  input  logic [7:0]  decoded_length,
  input  logic        decoded_extended,
  input  logic [63:0] decoded_payload,
  output int          fail_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  rec_byte;
    logic        last;
    logic        ok;
    logic [63:0] seq;
    logic [31:0] ts;
    logic [31:0] id;
    logic [7:0]  len;
    logic        ext;
    logic [63:0] pay;
  } codec_result_t;

  codec_result_t due_results[$];
  int fails = 0;
  int due_count = 0;

  logic [7:0] want_version = 8'd1;
  logic [7:0] want_port = 8'd0;

  // decoder image: position in the record and what has been gathered so far
  int          rx_pos = 0;
  logic [31:0] rx_crc = CRC_INIT;
  logic        rx_header_ok = 1'b1;
  logic [63:0] rx_seq = '0;
  logic [31:0] rx_ts = '0;
  logic [31:0] rx_id = '0;
  logic [7:0]  rx_len = '0;
  logic        rx_ext = 1'b0;
  logic [63:0] rx_pay = '0;
  logic [31:0] rx_crc_field = '0;

  assign fail_count = fails;
  assign results_due = due_count;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    return v;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fails++;
  endtask

  task automatic clear_rx();
    rx_pos = 0;
    rx_crc = CRC_INIT;
    rx_header_ok = 1'b1;
    rx_seq = '0;
    rx_ts = '0;
    rx_id = '0;
    rx_len = '0;
    rx_ext = 1'b0;
    rx_pay = '0;
    rx_crc_field = '0;
  endtask

  // Build the whole record for the frame on the input ports, one result per byte.
  task automatic predict_frame();
    logic [7:0] rec [64];
    logic [31:0] c;
    int n;
    codec_result_t r;
    for (int i = 0; i < 64; i++) rec[i] = 8'd0;
    for (int i = 0; i < 4; i++) rec[i] = MAGIC[i];
    rec[4] = want_version;
    rec[5] = TYPE_RX;
    rec[6] = port;
    rec[7] = {7'd0, extended_flag};
    for (int i = 0; i < 8; i++) rec[8 + i] = seq_number[8*i +: 8];
    for (int i = 0; i < 4; i++) begin
      rec[16 + i] = frame_time[8*i +: 8];
      rec[20 + i] = frame_id[8*i +: 8];
    end
    rec[24] = {4'd0, data_length};
    n = (data_length < MAX_PAYLOAD_BYTES) ? data_length : MAX_PAYLOAD_BYTES;
    for (int i = 0; i < n; i++) rec[25 + i] = payload[8*i +: 8];
    c = CRC_INIT;
    for (int i = 0; i < CRC_AT; i++) c = crc_step(c, rec[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) rec[CRC_AT + i] = c[8*i +: 8];
    for (int i = 0; i < RECORD_BYTES; i++) begin
      r = '0;
      r.rec_byte = rec[i];
      r.last = (i == RECORD_BYTES - 1);
      due_results.push_back(r);
    end
  endtask

  // Absorb one record byte; the final byte of a record yields the decode result.
  task automatic take_record_byte(logic [7:0] b);
    int p;
    int n;
    logic [63:0] mask;
    codec_result_t r;
    p = rx_pos;
    if (p < CRC_AT) rx_crc = crc_step(rx_crc, b);
    if (p < 4) begin
      if (b != MAGIC[p]) rx_header_ok = 1'b0;
    end else if (p == 4) begin
      if (b != want_version) rx_header_ok = 1'b0;
    end else if (p == 5) begin
      if (b != TYPE_RX) rx_header_ok = 1'b0;
    end else if (p == 6) begin
      if (b != want_port) rx_header_ok = 1'b0;
    end else if (p == 7) begin
      rx_ext = b[0];
    end else if (p < 16) begin
      rx_seq[8*(p-8) +: 8] = b;
    end else if (p < 20) begin
      rx_ts[8*(p-16) +: 8] = b;
    end else if (p < 24) begin
      rx_id[8*(p-20) +: 8] = b;
    end else if (p == 24) begin
      rx_len = b;
    end else if (p < 25 + MAX_PAYLOAD_BYTES) begin
      rx_pay[8*(p-25) +: 8] = b;
    end else if (p >= CRC_AT && p < CRC_AT + 4) begin
      rx_crc_field[8*(p-CRC_AT) +: 8] = b;
    end
    if (p + 1 < RECORD_BYTES) begin
      rx_pos = p + 1;
    end else begin
      n = (rx_len < MAX_PAYLOAD_BYTES) ? rx_len : MAX_PAYLOAD_BYTES;
      mask = (n >= 8) ? '1 : ((64'd1 << (8*n)) - 64'd1);
      r = '0;
      r.last = 1'b1;
      r.ok = rx_header_ok && (rx_len <= MAX_PAYLOAD_BYTES) && (rx_crc_field == ~rx_crc);
      r.seq = rx_seq;
      r.ts = rx_ts;
      r.id = rx_id;
      r.len = rx_len;
      r.ext = rx_ext;
      r.pay = rx_pay & mask;
      due_results.push_back(r);
      clear_rx();
    end
  endtask

  always @(posedge clk) begin
    codec_result_t want;
    if (rst) begin
      due_results.delete();
      want_version = 8'd1;
      want_port = 8'd0;
      clear_rx();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERSION: want_version = cfg_data;
          CFG_PORT:    want_port = cfg_data;
        endcase
      end
      // results leave before new items are worked, so compare them first
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report("result with none due, out_byte", 64'(out_byte), 64'd0);
        end else begin
          want = due_results.pop_front();
          if (out_byte !== want.rec_byte)
            report("out_byte", 64'(out_byte), 64'(want.rec_byte));
          if (last_flag !== want.last)
            report("last_flag", 64'(last_flag), 64'(want.last));
          if (record_ok !== want.ok)
            report("record_ok", 64'(record_ok), 64'(want.ok));
          if (decoded_sequence !== want.seq)
            report("decoded_sequence", decoded_sequence, want.seq);
          if (decoded_timestamp !== want.ts)
            report("decoded_timestamp", 64'(decoded_timestamp), 64'(want.ts));
          if (decoded_id !== want.id)
            report("decoded_id", 64'(decoded_id), 64'(want.id));
          if (decoded_length !== want.len)
            report("decoded_length", 64'(decoded_length), 64'(want.len));
          if (decoded_extended !== want.ext)
            report("decoded_extended", 64'(decoded_extended), 64'(want.ext));
          if (decoded_payload !== want.pay)
            report("decoded_payload", decoded_payload, want.pay);
        end
      end
      if (in_valid && in_ready) begin
        if (mode == MODE_ENCODE) predict_frame();
        else take_record_byte(record_byte);
      end
    end
    due_count = due_results.size();
  end

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import clrc_pkg::*;

  localparam int RB = REC_BYTES_DEF;
  localparam int MAXP = MAX_PAY_DEF;
  // cycles with no transaction on either channel before the run is called stuck
  localparam int STALL_LIMIT = 2000;
  // quiet cycles after the last result before touching the registers or ending
  localparam int SETTLE = 4;
  localparam int MAX_GAP = 20;

  typedef logic [63:0][7:0] rec_t;

  typedef struct packed {
    logic        md;
    logic [7:0]  prt;
    logic        ext;
    logic [63:0] seq;
    logic [31:0] ts;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [63:0] pay;
    logic [7:0]  rbyte;
  } in_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_VERSION;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_ENCODE;
  logic [7:0]  port = '0;
  logic        extended_flag = 1'b0;
  logic [63:0] seq_number = '0;
  logic [31:0] frame_time = '0;
  logic [31:0] frame_id = '0;
  logic [3:0]  data_length = '0;
  logic [63:0] payload = '0;
  logic [7:0]  record_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_flag;
  logic        record_ok;
  logic [63:0] decoded_sequence;
  logic [31:0] decoded_timestamp;
  logic [31:0] decoded_id;
  logic [7:0]  decoded_length;
  logic        decoded_extended;
  logic [63:0] decoded_payload;

  int fail_count;
  int results_due;

  // idle odds in percent for each side
  int send_idle = 17;
  int recv_idle = 75;
  int items_sent = 0;
  int dec_pos = 0;
  int stall_cycles = 0;
  int broken_kind = 0;
  logic [7:0] cur_version = 8'd1;
  logic [7:0] cur_port = 8'd0;

  always #5 clk = ~clk;

  can_log_record_codec u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .port, .extended_flag, .seq_number, .frame_time,
    .frame_id, .data_length, .payload, .record_byte,
    .out_valid, .out_ready, .out_byte, .last_flag, .record_ok, .decoded_sequence,
    .decoded_timestamp, .decoded_id, .decoded_length, .decoded_extended, .decoded_payload
  );

  clrc_record_checker #(.RECORD_BYTES(RB), .MAX_PAYLOAD_BYTES(MAXP)) u_check (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .port, .extended_flag, .seq_number, .frame_time,
    .frame_id, .data_length, .payload, .record_byte,
    .out_valid, .out_ready, .out_byte, .last_flag, .record_ok, .decoded_sequence,
    .decoded_timestamp, .decoded_id, .decoded_length, .decoded_extended, .decoded_payload,
    .fail_count, .results_due
  );

  // Receiver: stall at random, with the odds the current phase sets.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly random words, with all zeros and all ones now and then.
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Every field random: fields the current mode ignores still toggle.
  function automatic in_item_t random_item();
    in_item_t it;
    logic [63:0] w;
    w = pick64();
    it.md = 1'($urandom_range(0, 1));
    it.prt = w[7:0];
    it.ext = 1'($urandom_range(0, 1));
    it.seq = pick64();
    w = pick64();
    it.ts = w[31:0];
    w = pick64();
    it.id = w[63:32];
    it.dlc = 4'($urandom_range(0, 15));
    it.pay = pick64();
    it.rbyte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t frame_item();
    in_item_t it;
    it = random_item();
    it.md = MODE_ENCODE;
    // keep most frames within the payload limit, the rest at any dlc
    if ($urandom_range(0, 3) != 0) it.dlc = 4'($urandom_range(0, MAXP));
    return it;
  endfunction

  // Write the reflected CRC of bytes 0..35 into its slot.
  function automatic rec_t seal_crc(rec_t r);
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < CRC_AT; i++) begin
      c = c ^ {24'd0, r[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    c = ~c;
    for (int i = 0; i < 4; i++) r[CRC_AT + i] = c[8*i +: 8];
    return r;
  endfunction

  // Lay out a record as the decoder expects it. With junk set, the payload area
  // holds random bytes past the length too; the CRC covers them either way.
  function automatic rec_t frame_record(logic [7:0] len, bit junk);
    rec_t r;
    logic [63:0] seq;
    logic [63:0] pay;
    logic [63:0] w;
    int n;
    r = '0;
    seq = pick64();
    pay = pick64();
    w = pick64();
    for (int i = 0; i < 4; i++) r[i] = MAGIC[i];
    r[4] = cur_version;
    r[5] = TYPE_RX;
    r[6] = cur_port;
    r[7] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 8; i++) r[8 + i] = seq[8*i +: 8];
    for (int i = 0; i < 4; i++) begin
      r[16 + i] = w[8*i +: 8];
      r[20 + i] = w[32 + 8*i +: 8];
    end
    r[24] = len;
    n = (len < MAXP) ? len : MAXP;
    for (int i = 25; i < CRC_AT; i++) begin
      if (junk) r[i] = 8'($urandom_range(0, 255));
      else if (i - 25 < n) r[i] = pay[8*(i-25) +: 8];
    end
    return seal_crc(r);
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  // Enter and leave at a falling edge; valid is left high for the caller to drive.
  task automatic put(in_item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.md;
    port <= it.prt;
    extended_flag <= it.ext;
    seq_number <= it.seq;
    frame_time <= it.ts;
    frame_id <= it.id;
    data_length <= it.dlc;
    payload <= it.pay;
    record_byte <= it.rbyte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (it.md == MODE_DECODE) dec_pos = (dec_pos + 1) % RB;
    items_sent++;
  endtask

  task automatic put_byte(logic [7:0] b);
    in_item_t it;
    it = random_item();
    it.md = MODE_DECODE;
    it.rbyte = b;
    put(it);
  endtask

  // Hold the sender until every due result is out, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_VERSION) cur_version = val;
    else cur_port = val;
  endtask

  // Finish whatever partial record the decoder holds with noise bytes.
  task automatic realign();
    while (dec_pos != 0) put_byte(8'($urandom_range(0, 255)));
  endtask

  // Send a record byte by byte; with mix set, slip one frame in mid-record.
  task automatic feed_record(rec_t r, bit mix);
    int cut;
    cut = $urandom_range(1, RB - 1);
    realign();
    for (int i = 0; i < RB; i++) begin
      if (mix && i == cut) put(frame_item());
      put_byte(r[i]);
    end
  endtask

  task automatic random_stretch(int count);
    int stop;
    int idx;
    rec_t r;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          r = frame_record(8'($urandom_range(0, MAXP)), 1'($urandom_range(0, 1)));
          feed_record(r, $urandom_range(0, 3) == 0);
        end
        3, 4: begin
          // broken records, one kind after the other with random content
          r = frame_record(8'($urandom_range(0, MAXP)), 1'($urandom_range(0, 1)));
          case (broken_kind)
            0: begin
              // bad magic, version, type or port behind a good CRC
              idx = $urandom_range(0, 6);
              r[idx] = r[idx] ^ 8'($urandom_range(1, 255));
              r = seal_crc(r);
            end
            1: begin
              idx = CRC_AT + $urandom_range(0, 3);
              r[idx] = r[idx] ^ 8'($urandom_range(1, 255));
            end
            2: r = frame_record(8'($urandom_range(MAXP + 1, 255)), 1'($urandom_range(0, 1)));
            default: begin
              // corrupt a body byte and leave the CRC stale
              idx = $urandom_range(7, CRC_AT - 1);
              r[idx] = r[idx] ^ 8'($urandom_range(1, 255));
            end
          endcase
          broken_kind = (broken_kind + 1) % 4;
          feed_record(r, 1'b0);
        end
        5, 6, 7: put(frame_item());
        8: repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
        default: wait_drained();
      endcase
    end
  endtask

  initial begin
    in_item_t it;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames under the reset register values: all zeros, all ones with the
    // longest dlc, the payload limit and one past it, a single byte.
    it = '0;
    it.md = MODE_ENCODE;
    put(it);
    it = '1;
    it.md = MODE_ENCODE;
    put(it);
    it = frame_item();
    it.dlc = 4'(MAXP);
    put(it);
    it.dlc = 4'(MAXP + 1);
    put(it);
    it = frame_item();
    it.dlc = 4'd1;
    it.ext = 1'b1;
    put(it);
    // a good record with junk past its length, interrupted by a frame
    feed_record(frame_record(8'(MAXP - 3), 1'b1), 1'b1);
    wait_drained();

    random_stretch(100);
    wait_drained();
    write_reg(CFG_VERSION, 8'hFF);
    write_reg(CFG_PORT, 8'hFF);

    send_idle = 75;
    recv_idle = 17;
    random_stretch(135);
    wait_drained();
    write_reg(CFG_VERSION, 8'h00);
    write_reg(CFG_PORT, 8'($urandom_range(1, 254)));

    send_idle = 0;
    recv_idle = 0;
    random_stretch(65);
    wait_drained();
    write_reg(CFG_VERSION, 8'($urandom_range(2, 254)));
    write_reg(CFG_PORT, 8'h00);
    random_stretch(65);
    wait_drained();

    if (fail_count == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
